// ----- hdl/smw_pkg.sv -----
// sliding window median package: shared constants and the cell link type
// used by smw_cell, smw_ring, sliding_window_median_core and the bench
`default_nettype none

package smw_pkg;

   localparam int MAX_WINDOW_DEF    = 64;
   localparam int SAMPLE_WIDTH_DEF  = 32;
   localparam int CSR_WIDTH         = 7;
   localparam int WINDOW_SIZE_RESET = 3;

   // flags one cell shows to its neighbors
   typedef struct packed {
      logic a_le;   // value after removal is valid and <= key
      logic s_le;   // stored value <= key
   } smw_link_type;

endpackage

`default_nettype wire

// ----- hdl/sliding_window_median_core.sv -----
// sliding window median filter top level: cell row, arrival ring, output stage
// depends on smw_pkg, smw_cell and smw_ring
//
// usage
//   req channel: one signed sample per request in req_tdata, req_tuser high
//   empties the window before that sample enters
//   rsp channel: the median of the full window in rsp_tdata, lower middle
//   for an even window size; no response while the window is still filling
//   csr channel: csr_data sets the window size (0 acts as 1, larger than
//   MAX_WINDOW acts as MAX_WINDOW) and empties the window; write only idle
// timing
//   one request per clock while req_tready is high; the sorted row of cells
//   is written when a request is taken, the median is picked from the row
//   into the output register when not stalled and shows on rsp from there
// reset
//   window empty, window size 3, no response pending
// stalls
//   the output register and the pick stage hold one median each; with both
//   full and rsp_tready low, req_tready drops so the row keeps its contents
`default_nettype none

module sliding_window_median_core
   import smw_pkg::*;
#(
   parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request channel
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      req_tdata,  // sample
   input  wire logic                                   req_tuser,  // restart
   // response channel
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic      [((SAMPLE_WIDTH+7)/8)*8-1:0]      rsp_tdata,  // median
   // window size register
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [CSR_WIDTH-1:0]                   csr_data
);

   localparam int SW       = SAMPLE_WIDTH;
   localparam int DATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
   localparam int PTR_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int RST_SIZE = (WINDOW_SIZE_RESET > MAX_WINDOW) ? MAX_WINDOW
                                                              : WINDOW_SIZE_RESET;
   localparam int RST_MID  = (RST_SIZE - 1) / 2;

   // control registers
   logic [CNT_W-1:0] size_ff, size_in;     // effective window size
   logic [PTR_W-1:0] mid_ff, mid_in;       // rank of the median
   logic [CNT_W-1:0] fill_ff, fill_in;     // samples in the window
   logic [PTR_W-1:0] ptr_ff, ptr_in;       // ring slot of the next write
   logic             pend_ff, pend_in;     // median waiting to be picked
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]    rsp_data_ff;

   logic             req_fire;
   logic             csr_fire;
   logic             stall;
   logic             pick;
   logic [SW-1:0]    key;
   logic [SW-1:0]    old_key;
   logic [CNT_W-1:0] fill_now;
   logic [CNT_W-1:0] fill_after_rm;
   logic             remove;
   logic [PTR_W-1:0] wr_ptr;
   logic [CNT_W-1:0] ptr_inc;
   logic [31:0]      csr_ext;

   // cell row wiring
   logic [SW-1:0]    cell_val   [MAX_WINDOW];
   logic [SW-1:0]    cell_a_val [MAX_WINDOW];
   smw_link_type     cell_link  [MAX_WINDOW];

   // handshakes: hold input only when both median stages are full and blocked
   assign stall      = pend_ff && rsp_valid_ff && !rsp_tready;
   assign req_tready = !stall;
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_fire   = csr_valid && csr_ready;
   assign pick       = pend_ff && !stall;

   assign key = req_tdata[SW-1:0];

   // window bookkeeping of the current request
   always_comb begin
      fill_now      = req_tuser ? '0 : fill_ff;
      wr_ptr        = req_tuser ? '0 : ptr_ff;
      remove        = (fill_now == size_ff);
      fill_after_rm = remove ? fill_now - CNT_W'(1) : fill_now;
      ptr_inc       = CNT_W'(wr_ptr) + CNT_W'(1);
   end

   // effective window size from the written value
   always_comb begin
      csr_ext = 32'(csr_data);
      priority if (csr_ext == 32'd0) begin
         size_in = CNT_W'(1);
      end else if (csr_ext > 32'(MAX_WINDOW)) begin
         size_in = CNT_W'(MAX_WINDOW);
      end else begin
         size_in = CNT_W'(csr_ext);
      end
      mid_in = PTR_W'((size_in - CNT_W'(1)) >> 1);
   end

   // next state of the bookkeeping
   always_comb begin
      fill_in      = fill_ff;
      ptr_in       = ptr_ff;
      pend_in      = pend_ff && stall;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (pick) begin
         rsp_valid_in = 1'b1;
      end
      if (csr_fire) begin
         fill_in = '0;
         ptr_in  = '0;
      end else if (req_fire) begin
         fill_in = remove ? fill_now : fill_now + CNT_W'(1);
         ptr_in  = (ptr_inc >= size_ff) ? '0 : ptr_inc[PTR_W-1:0];
         // a median exists once the window is full after this sample
         pend_in = remove || ((fill_now + CNT_W'(1)) == size_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= CNT_W'(RST_SIZE);
         mid_ff       <= PTR_W'(RST_MID);
         fill_ff      <= '0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_fire) begin
            size_ff <= size_in;
            mid_ff  <= mid_in;
         end
         fill_ff      <= fill_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // median pick from the row into the output register when not stalled
   always_ff @(posedge clock) begin
      if (pick) begin
         rsp_data_ff <= cell_val[mid_ff];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(rsp_data_ff);

   // arrival ring, prefetching the slot the next request overwrites
   smw_ring #(
      .DEPTH (MAX_WINDOW),
      .SW    (SW),
      .AW    (PTR_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (wr_ptr),
      .wr_data (key),
      .rd_addr (ptr_in),
      .rd_data (old_key)
   );

   // sorted row of cells, ascending from cell 0
   for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
      logic [SW-1:0] left_a_val;
      smw_link_type  left_link;
      logic [SW-1:0] right_val;
      smw_link_type  right_link;

      if (j == 0) begin : g_first
         assign left_a_val = '0;
         assign left_link  = '{a_le: 1'b1, s_le: 1'b0};
      end else begin : g_inner_l
         assign left_a_val = cell_a_val[j-1];
         assign left_link  = cell_link[j-1];
      end

      if (j == MAX_WINDOW - 1) begin : g_last
         assign right_val  = '0;
         assign right_link = '{a_le: 1'b0, s_le: 1'b0};
      end else begin : g_inner_r
         assign right_val  = cell_val[j+1];
         assign right_link = cell_link[j+1];
      end

      smw_cell #(
         .IDX   (j),
         .SW    (SW),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock         (clock),
         .en            (req_fire),
         .key           (key),
         .old           (old_key),
         .remove        (remove),
         .fill_now      (fill_now),
         .fill_after_rm (fill_after_rm),
         .left_a_val    (left_a_val),
         .left_link     (left_link),
         .right_val     (right_val),
         .right_link    (right_link),
         .val           (cell_val[j]),
         .a_val         (cell_a_val[j]),
         .link          (cell_link[j])
      );
   end

`ifndef SYNTH
   a_fill_in_range : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= size_ff)
      else $error("fill count above window size");

   a_ptr_in_range : assert property (@(posedge clock) disable iff (reset)
      CNT_W'(ptr_ff) < size_ff)
      else $error("ring pointer outside window");

   a_mid_in_range : assert property (@(posedge clock) disable iff (reset)
      CNT_W'(mid_ff) < size_ff)
      else $error("median rank outside window");

   a_rsp_from_pick : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pend_ff))
      else $error("response without a pending median");
`endif

endmodule

`default_nettype wire

// ----- hdl/smw_cell.sv -----
// one slot of the sorted window: removes the leaving sample and inserts the new one
// depends on smw_pkg (link type and default sample width)
`default_nettype none

module smw_cell
   import smw_pkg::*;
#(
   parameter int IDX   = 0,
   parameter int SW    = SAMPLE_WIDTH_DEF,
   parameter int CNT_W = 7
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [SW-1:0]     key,
   input  wire logic [SW-1:0]     old,
   input  wire logic              remove,
   input  wire logic [CNT_W-1:0]  fill_now,
   input  wire logic [CNT_W-1:0]  fill_after_rm,
   input  wire logic [SW-1:0]     left_a_val,
   input  wire smw_link_type      left_link,
   input  wire logic [SW-1:0]     right_val,
   input  wire smw_link_type      right_link,
   output logic      [SW-1:0]     val,
   output logic      [SW-1:0]     a_val,
   output smw_link_type           link
);

   logic [SW-1:0] val_ff;
   logic [SW-1:0] val_in;
   logic          cur_valid;
   logic          rm;
   logic          s_ge_old;

   always_comb begin
      cur_valid   = fill_now > CNT_W'(IDX);
      s_ge_old    = $signed(val_ff) >= $signed(old);
      link.s_le   = $signed(val_ff) <= $signed(key);
      // every valid slot at or above the leaving value takes its right neighbor
      rm          = remove && cur_valid && s_ge_old;
      a_val       = rm ? right_val : val_ff;
      link.a_le   = (fill_after_rm > CNT_W'(IDX)) && (rm ? right_link.s_le : link.s_le);
      priority if (link.a_le) begin
         val_in = a_val;
      end else if (left_link.a_le) begin
         val_in = key;
      end else begin
         val_in = left_a_val;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         val_ff <= val_in;
      end
   end

   assign val = val_ff;

endmodule

`default_nettype wire

// ----- hdl/smw_ring.sv -----
// arrival order ring of the window with a registered read of the next slot
// depends on smw_pkg
`default_nettype none

module smw_ring
   import smw_pkg::*;
#(
   parameter int DEPTH = MAX_WINDOW_DEF,
   parameter int SW    = SAMPLE_WIDTH_DEF,
   parameter int AW    = 6
) (
   input  wire logic           clock,
   input  wire logic           wr_en,
   input  wire logic [AW-1:0]  wr_addr,
   input  wire logic [SW-1:0]  wr_data,
   input  wire logic [AW-1:0]  rd_addr,
   output logic      [SW-1:0]  rd_data
);

   logic [SW-1:0] mem [DEPTH];
   logic [SW-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // write data forwarded when the same slot is written and read
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_ff <= wr_data;
      end else begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

`default_nettype wire

// ----- verif/tb_sliding_window_median_core.sv -----
// self-checking bench for sliding_window_median_core: sorted-window predictor,
// stream drivers with random gaps on both sides; depends on smw_pkg and the rtl
`default_nettype none

module tb_sliding_window_median_core
   import smw_pkg::*;
();

   localparam int DATA_BITS = ((SAMPLE_WIDTH_DEF + 7) / 8) * 8;

   // keeps its own copy of the window and queues the medians the block owes
   class window_median_predictor;
      logic signed [SAMPLE_WIDTH_DEF-1:0] arrival [MAX_WINDOW_DEF];
      logic signed [SAMPLE_WIDTH_DEF-1:0] ranked [MAX_WINDOW_DEF];
      logic signed [SAMPLE_WIDTH_DEF-1:0] medians_due [$];
      logic [CSR_WIDTH-1:0] size_reg;
      int fill;
      int slot;
      int mismatches;
      int medians_predicted;

      function new();
         size_reg = CSR_WIDTH'(WINDOW_SIZE_RESET);
         fill = 0;
         slot = 0;
         mismatches = 0;
         medians_predicted = 0;
      endfunction

      function int span();
         int w;
         w = int'(size_reg);
         if (w == 0) w = 1;
         if (w > MAX_WINDOW_DEF) w = MAX_WINDOW_DEF;
         return w;
      endfunction

      function int pending();
         return medians_due.size();
      endfunction

      function void set_window(logic [CSR_WIDTH-1:0] value);
         size_reg = value;
         fill = 0;
         slot = 0;
      endfunction

      function void take_sample(logic signed [SAMPLE_WIDTH_DEF-1:0] value, bit restart);
         int w;
         int i;
         int hit;
         w = span();
         if (restart) begin
            fill = 0;
            slot = 0;
         end
         if (slot >= w) slot = 0;
         // full window: drop one copy of the oldest sample
         if (fill >= w) begin
            hit = -1;
            for (i = 0; i < fill; i++)
               if (hit < 0 && ranked[i] == arrival[slot]) hit = i;
            if (hit >= 0) begin
               for (i = hit; i + 1 < fill; i++) ranked[i] = ranked[i+1];
               fill--;
            end
         end
         if (fill < MAX_WINDOW_DEF) begin
            i = fill;
            while (i > 0 && ranked[i-1] > value) begin
               ranked[i] = ranked[i-1];
               i--;
            end
            ranked[i] = value;
            fill++;
         end
         arrival[slot] = value;
         slot = (slot + 1 >= w) ? 0 : slot + 1;
         if (fill == w) begin
            medians_due = {medians_due, ranked[(w - 1) / 2]};
            medians_predicted++;
         end
      endfunction

      function void flag(string what, logic [DATA_BITS-1:0] want, logic [DATA_BITS-1:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("median %s: expected %0d (%h) got %0d (%h)", what,
                     $signed(want), want, $signed(got), got);
      endfunction

      function void check_median(logic [DATA_BITS-1:0] got);
         logic signed [SAMPLE_WIDTH_DEF-1:0] want;
         if (medians_due.size() == 0) begin
            flag("without pending request", '0, got);
         end else begin
            want = medians_due.pop_front();
            if (got !== DATA_BITS'(want)) flag("mismatch", DATA_BITS'(want), got);
         end
      endfunction
   endclass

   // every input known from time zero
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DATA_BITS-1:0]  req_tdata  = '0;   // sample
   logic                  req_tuser  = 1'b0; // restart
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [DATA_BITS-1:0]  rsp_tdata;         // median
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_WIDTH-1:0]  csr_data   = '0;

   // per-phase switches for gap-free stretches
   bit req_steady = 1'b0;
   bit rsp_steady = 1'b0;

   window_median_predictor window_model = new();

   sliding_window_median_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // one request; tvalid stays high after acceptance so back-to-back requests
   // never lower and raise it in the same step
   task automatic push_sample(logic signed [SAMPLE_WIDTH_DEF-1:0] value, bit restart);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_BITS'(value);
      req_tuser  <= restart;
      do @(posedge clock); while (!req_tready);
      window_model.take_sample(value, restart);
   endtask

   // let the last responses drain, then give the pipe time for requests
   // that produce no median
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (window_model.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_window_size(logic [CSR_WIDTH-1:0] value);
      settle_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      window_model.set_window(value);
   endtask

   // mix of full-range values, a narrow band that makes ties, and the extremes
   function automatic logic signed [SAMPLE_WIDTH_DEF-1:0] draw_sample();
      case ($urandom_range(0, 5))
         0: return $signed($urandom_range(0, 8)) - 4;
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7fff_ffff;
               1: return 32'sh8000_0000;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         2: return $signed($urandom_range(0, 100)) - 50;
         default: return $urandom;
      endcase
   endfunction

   // response side: random stall per response, accepted median checked in order
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_steady ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         window_model.check_median(rsp_tdata);
      end
   end

   // main sequence: reset, directed checks at the reset window size, then
   // random phases over a range of window sizes including both extremes
   initial begin
      int sizes [12];
      int phase;
      int count;
      int w;
      int start_medians;
      sizes = '{0, 1, 2, 64, 127, 65, 4, 7, 33, 63, 8, 3};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // window of three out of reset: field extremes first
      push_sample(32'sh7fff_ffff, 1'b0);
      push_sample(32'sh8000_0000, 1'b0);
      push_sample(32'sd0, 1'b0);
      push_sample(-32'sd1, 1'b0);
      push_sample(32'sd1, 1'b0);
      // ties: leaving value equals others in the window
      push_sample(32'sd7, 1'b0);
      push_sample(32'sd7, 1'b0);
      push_sample(32'sd7, 1'b0);
      push_sample(-32'sd7, 1'b0);
      push_sample(32'sd7, 1'b0);
      // restart on a full window, then restart while still filling
      push_sample(32'sh8000_0000, 1'b1);
      push_sample(32'sh7fff_ffff, 1'b0);
      push_sample(32'sd5, 1'b1);
      push_sample(32'sd9, 1'b0);
      push_sample(32'sd3, 1'b0);
      push_sample(32'sh5555_5555, 1'b0);
      push_sample(32'shaaaa_aaaa, 1'b0);
      push_sample(32'sd0, 1'b1);
      push_sample(32'sd0, 1'b0);
      push_sample(32'sd0, 1'b0);

      for (phase = 0; phase < 12; phase++) begin
         // a csr write also empties the window; zero acts as one, above max saturates
         write_window_size(CSR_WIDTH'(sizes[phase]));
         req_steady = ($urandom_range(0, 3) == 0);
         rsp_steady = ($urandom_range(0, 3) == 0);
         w = window_model.span();
         start_medians = window_model.medians_predicted;
         count = 0;
         // mostly clean streams; restarts rare enough that big windows still fill
         while (count < 120 || window_model.medians_predicted - start_medians < 40) begin
            push_sample(draw_sample(), $urandom_range(0, 4 * w + 8) == 0);
            count++;
         end
      end

      settle_idle();
      repeat (8) @(posedge clock);
      if (window_model.mismatches == 0 && window_model.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- sliding_window_median_core.f -----
hdl/smw_pkg.sv
hdl/smw_cell.sv
hdl/smw_ring.sv
hdl/sliding_window_median_core.sv
verif/tb_sliding_window_median_core.sv
